// File: src/mtf_pkg.sv
// ----------------------------------------------------------------------------
// mtf_pkg: shared constants and types for the move-to-front list
// sizes of the cell row, action codes and the control bundle to the cells
// ----------------------------------------------------------------------------
package mtf_pkg;

    localparam int LIST_DEPTH = 256;
    localparam int CARD_BITS  = 8;

    localparam int ACTION_W = 2;
    localparam int CARD_W   = 8;
    localparam int POS_W    = 9;

    localparam int IDX_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
    localparam int STEP_W = (IDX_W > 1) ? $clog2(IDX_W) : 1;

    localparam logic [ACTION_W-1:0] ACT_APPEND  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_QUERY   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd2;

    typedef logic [CARD_BITS-1:0] card_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    // control bundle from the sequencer to every cell
    typedef struct packed {
        logic              append;
        logic              query;
        logic              step_en;
        logic [STEP_W-1:0] step;
        logic              apply;
        logic              found;
        card_t             card;
        cnt_t              count;
    } chain_ctrl_t;

    // first-match summary read from the last cell
    typedef struct packed {
        logic found;
        idx_t hit;
    } chain_hit_t;

endpackage

// File: src/mtf_in_if.sv
// ----------------------------------------------------------------------------
// mtf_in_if: input channel
// valid/ready channel carrying one action and card per item
// ----------------------------------------------------------------------------
interface mtf_in_if
    import mtf_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [CARD_W-1:0]   card;

    modport source (output valid, output action, output card, input ready);
    modport sink   (input valid, input action, input card, output ready);
endinterface

// File: src/mtf_out_if.sv
// ----------------------------------------------------------------------------
// mtf_out_if: result channel
// valid/ready channel carrying one query result per item
// ----------------------------------------------------------------------------
interface mtf_out_if
    import mtf_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] position;
    logic             found;

    modport source (output valid, output position, output found, input ready);
    modport sink   (input valid, input position, input found, output ready);
endinterface

// File: src/mtf_cell.sv
// ----------------------------------------------------------------------------
// mtf_cell: one list entry
// holds one card, compares it on a query and takes part in the prefix scan
// ----------------------------------------------------------------------------
module mtf_cell
    import mtf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  chain_ctrl_t ctrl,
    input  idx_t        self_idx,
    input  card_t       prev_value,
    input  logic        prev_seen,
    input  logic        partner_seen,
    input  idx_t        partner_idx,
    output card_t       value,
    output logic        seen,
    output idx_t        idx
);

    card_t value_reg, value_next;
    logic  seen_reg, seen_next;
    idx_t  idx_reg, idx_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.append && (CNT_W'(self_idx) == ctrl.count))
        begin
            value_next = ctrl.card;
        end
        else if (ctrl.apply && ctrl.found && !prev_seen)
        begin
            // entries up to the hit move back by one
            value_next = prev_value;
        end
    end

    always_comb
    begin
        seen_next = seen_reg;
        idx_next  = idx_reg;
        if (ctrl.query)
        begin
            seen_next = (CNT_W'(self_idx) < ctrl.count) && (value_reg == ctrl.card);
            idx_next  = self_idx;
        end
        else if (ctrl.step_en && partner_seen)
        begin
            // a lower match always wins
            seen_next = 1'b1;
            idx_next  = partner_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        idx_reg   <= idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
        end
        else
        begin
            seen_reg <= seen_next;
        end
    end

    assign value = value_reg;
    assign seen  = seen_reg;
    assign idx   = idx_reg;

endmodule

// File: src/mtf_chain.sv
// ----------------------------------------------------------------------------
// mtf_chain: row of list cells
// wires neighbors for the shift and partners at distance 2^step for the scan
// ----------------------------------------------------------------------------
module mtf_chain
    import mtf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  chain_ctrl_t ctrl,
    output chain_hit_t  hit
);

    card_t           value [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] seen;
    idx_t            idx   [LIST_DEPTH];

    genvar i, k;
    generate
        for (i = 0; i < LIST_DEPTH; i++)
        begin : g_cell
            logic [IDX_W-1:0] pk_seen;
            idx_t             pk_idx [IDX_W];
            card_t            prev_value;
            logic             prev_seen;

            for (k = 0; k < IDX_W; k++)
            begin : g_partner
                if (i >= (1 << k))
                begin : g_has
                    assign pk_seen[k] = seen[i - (1 << k)];
                    assign pk_idx[k]  = idx[i - (1 << k)];
                end
                else
                begin : g_none
                    assign pk_seen[k] = 1'b0;
                    assign pk_idx[k]  = '0;
                end
            end

            if (i == 0)
            begin : g_head
                // the front entry takes the queried card
                assign prev_value = ctrl.card;
                assign prev_seen  = 1'b0;
            end
            else
            begin : g_body
                assign prev_value = value[i-1];
                assign prev_seen  = seen[i-1];
            end

            mtf_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctrl         (ctrl),
                .self_idx     (IDX_W'(i)),
                .prev_value   (prev_value),
                .prev_seen    (prev_seen),
                .partner_seen (pk_seen[ctrl.step]),
                .partner_idx  (pk_idx[ctrl.step]),
                .value        (value[i]),
                .seen         (seen[i]),
                .idx          (idx[i])
            );
        end
    endgenerate

    assign hit.found = seen[LIST_DEPTH-1];
    assign hit.hit   = idx[LIST_DEPTH-1];

endmodule

// File: src/move_to_front_list_top.sv
// ----------------------------------------------------------------------------
// move_to_front_list_top: move-to-front list of cards
// keeps an ordered card list, appends, restarts and answers position queries
// ----------------------------------------------------------------------------
// usage
//   in_ch carries one item per handshake: action (append, query, restart) and
//   a card. out_ch carries one result per query: the 1-based position of the
//   first matching entry before the move, and found. absent cards give 0/0.
// timing
//   append and restart give no result; the next item is taken in the
//   following cycle.
//   a query runs a compare in all cells at the accept edge, IDX_W prefix-scan
//   steps in which each cell combines with the cell 2^step below it, then a
//   step that registers the result and shifts the entries in front of the hit
//   back by one. no new item is taken until the query is done; the scan depth
//   is log2 of the list depth.
// reset
//   list count, sequencer and result valid clear; card storage is not reset
//   and is only read below the count.
// stall
//   the result sits in an output register; new appends and restarts are taken
//   while it waits. a finished query holds in its last cycle until the result
//   register is free.
// ----------------------------------------------------------------------------
module move_to_front_list_top
    import mtf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    mtf_in_if.sink    in_ch,
    mtf_out_if.source out_ch
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    cnt_t              count_reg, count_next;
    card_t             card_reg;
    logic              out_valid_reg, out_valid_next;
    logic [POS_W-1:0]  position_reg, position_next;
    logic              found_reg, found_next;

    logic        in_fire;
    logic        out_free;
    logic        apply;
    card_t       in_card;
    chain_ctrl_t ctrl;
    chain_hit_t  hit;

    // only idle takes items
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign in_card     = CARD_BITS'(in_ch.card);

    // result register free when empty or being taken this cycle
    assign out_free = !out_valid_reg || out_ch.ready;
    assign apply    = (state_reg == ST_DONE) && out_free;

    always_comb
    begin
        ctrl.append  = in_fire && (in_ch.action == ACT_APPEND)
                       && (count_reg < CNT_W'(LIST_DEPTH));
        ctrl.query   = in_fire && (in_ch.action == ACT_QUERY);
        ctrl.step_en = (state_reg == ST_SCAN);
        ctrl.step    = step_reg;
        ctrl.apply   = apply;
        ctrl.found   = hit.found;
        ctrl.card    = in_fire ? in_card : card_reg;
        ctrl.count   = count_reg;
    end

    mtf_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .hit   (hit)
    );

    // sequencer and list count
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        count_next = count_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_ch.action)
                        ACT_APPEND:
                        begin
                            if (ctrl.append)
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        ACT_QUERY:
                        begin
                            state_next = ST_SCAN;
                            step_next  = '0;
                        end
                        ACT_RESTART:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            // unused action code, no effect
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (step_reg == STEP_W'(IDX_W - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        position_next  = position_reg;
        found_next     = found_reg;
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (apply)
        begin
            out_valid_next = 1'b1;
            found_next     = hit.found;
            position_next  = hit.found ? POS_W'(CNT_W'(hit.hit) + CNT_W'(1)) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            card_reg <= in_card;
        end
        position_reg <= position_next;
        found_reg    <= found_next;
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.position = position_reg;
    assign out_ch.found    = found_reg;

endmodule

// File: tb/sv/move_to_front_list_top_test.sv
// ----------------------------------------------------------------------------
// move_to_front_list_top_test: self-checking bench for the move-to-front list
// drives append, query, restart and unused action items through the input
// channel, keeps its own copy of the card list to predict every query result,
// and checks each result in order while the sender idles and the receiver
// stalls at random in all but the last phase

// one query result as seen on the result channel
typedef struct packed {
    logic [mtf_pkg::POS_W-1:0] position;
    logic                      found;
} lookup_result_t;

// card list copy and queue of query results still to come
class lookup_tracker;
    mtf_pkg::card_t cards [mtf_pkg::LIST_DEPTH];
    int unsigned    cards_held;
    lookup_result_t awaited [$];
    int unsigned    errors;

    function new();
        cards_held = 0;
        errors     = 0;
    endfunction

    function bit is_full();
        return cards_held >= mtf_pkg::LIST_DEPTH;
    endfunction

    function int unsigned pending();
        return awaited.size();
    endfunction

    function int unsigned failures();
        return errors + awaited.size();
    endfunction

    // apply one accepted item to the list copy
    function void record_item(input logic [mtf_pkg::ACTION_W-1:0] action,
                              input logic [mtf_pkg::CARD_W-1:0] card);
        mtf_pkg::card_t key;
        lookup_result_t res;
        int             hit;
        int             i;
        key = mtf_pkg::card_t'(card);
        case (action)
            mtf_pkg::ACT_APPEND:
            begin
                if (cards_held < mtf_pkg::LIST_DEPTH)
                begin
                    cards[cards_held] = key;
                    cards_held++;
                end
            end
            mtf_pkg::ACT_RESTART:
            begin
                cards_held = 0;
            end
            mtf_pkg::ACT_QUERY:
            begin
                hit = -1;
                for (i = 0; i < int'(cards_held) && hit < 0; i++)
                begin
                    if (cards[i] == key)
                        hit = i;
                end
                if (hit < 0)
                begin
                    res.position = '0;
                    res.found    = 1'b0;
                end
                else
                begin
                    res.position = mtf_pkg::POS_W'(hit + 1);
                    res.found    = 1'b1;
                    for (i = hit; i > 0; i--)
                        cards[i] = cards[i - 1];
                    cards[0] = key;
                end
                // queue the expected result at the tail
                awaited.insert(awaited.size(), res);
            end
            default:
            begin
            end
        endcase
    endfunction

    // compare one accepted result with the oldest query result waiting
    function void check_lookup(input logic [mtf_pkg::POS_W-1:0] position,
                               input logic found);
        lookup_result_t want;
        if (awaited.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: position %0d found %0b", position, found);
            return;
        end
        want = awaited.pop_front();
        if (position !== want.position || found !== want.found)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch: position %0d found %0b, wanted position %0d found %0b",
                         position, found, want.position, want.found);
        end
    endfunction
endclass

module move_to_front_list_top_test
    import mtf_pkg::*;
;
    // action code outside the defined set, the block must ignore it
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    // items per idling phase, three phases in all
    localparam int PHASE_ITEMS = 650;
    // length of one query, used to size the drain time
    localparam int QUERY_CYCLES = IDX_W + 2;

    logic clk = 1'b0;
    logic rst_n;

    mtf_in_if  in_ch ();
    mtf_out_if out_ch ();

    move_to_front_list_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    lookup_tracker tracker = new();

    // idle odds in percent for each side, changed per phase
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    // items that reach the list (ignored items are not counted)
    int items_taken   = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: ready changes at the falling edge, randomly low
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // every accepted result goes to the checker
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            tracker.check_lookup(out_ch.position, out_ch.found);
    end

    function automatic logic [CARD_W-1:0] rand_card();
        return CARD_W'($urandom_range(255));
    endfunction

    // present one item, idling first at random, and wait for the handshake
    task automatic send_item(input logic [ACTION_W-1:0] action,
                             input logic [CARD_W-1:0] card);
        bit counts;
        counts = (action == ACT_QUERY) || (action == ACT_RESTART) ||
                 (action == ACT_APPEND && !tracker.is_full());
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            // one assignment per falling edge: valid drops only while idling
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.action <= action;
        in_ch.card   <= card;
        do
            @(posedge clk);
        while (!(in_ch.ready === 1'b1));
        tracker.record_item(action, card);
        if (counts)
            items_taken++;
    endtask

    // short list from a tiny alphabet so that duplicates and misses are common
    task automatic play_small_list();
        logic [CARD_W-1:0] alphabet [12];
        int                n_alpha;
        int                n_load;
        int                n_query;
        int                pick;
        int                i;
        n_alpha = $urandom_range(12, 1);
        for (i = 0; i < n_alpha; i++)
            alphabet[i] = rand_card();
        // mostly start clean, sometimes keep whatever the list holds
        if ($urandom_range(99) < 80)
            send_item(ACT_RESTART, rand_card());
        n_load = $urandom_range(16, 0);
        for (i = 0; i < n_load; i++)
            send_item(ACT_APPEND, alphabet[$urandom_range(n_alpha - 1, 0)]);
        n_query = $urandom_range(20, 1);
        for (i = 0; i < n_query; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
                send_item(ACT_QUERY, alphabet[$urandom_range(n_alpha - 1, 0)]);
            else if (pick < 85)
                send_item(ACT_QUERY, rand_card());
            else if (pick < 92)
                send_item(ACT_APPEND, alphabet[$urandom_range(n_alpha - 1, 0)]);
            else if (pick < 95)
                send_item(ACT_RESTART, rand_card());
            else
                send_item(ACT_UNUSED, rand_card());
        end
    endtask

    // fill the whole list with a permutation of all cards, then query deep
    task automatic play_full_list();
        int unsigned stride;
        int unsigned offset;
        int          n_extra;
        int          n_query;
        int          i;
        // odd stride makes the fill a permutation, so every card is unique
        stride = 2 * $urandom_range(127) + 1;
        offset = $urandom_range(255);
        send_item(ACT_RESTART, rand_card());
        for (i = 0; i < LIST_DEPTH; i++)
            send_item(ACT_APPEND, CARD_W'(i * stride + offset));
        // appends to a full list are dropped
        n_extra = $urandom_range(3, 1);
        for (i = 0; i < n_extra; i++)
            send_item(ACT_APPEND, rand_card());
        // last entry sits at the highest position
        send_item(ACT_QUERY, CARD_W'((LIST_DEPTH - 1) * stride + offset));
        // old front entry has moved back to the second place
        send_item(ACT_QUERY, CARD_W'(offset));
        // the entry shifted into the last place
        send_item(ACT_QUERY, CARD_W'((LIST_DEPTH - 2) * stride + offset));
        n_query = $urandom_range(30, 10);
        for (i = 0; i < n_query; i++)
        begin
            if ($urandom_range(99) < 90)
                send_item(ACT_QUERY, rand_card());
            else
                send_item(ACT_UNUSED, rand_card());
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.action = ACT_APPEND;
        in_ch.card   = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 7;
        recv_idle_pct = 50;

        // directed: empty list, extremes, duplicates, unused code, restart
        send_item(ACT_QUERY, 8'h00);      // query on an empty list
        send_item(ACT_APPEND, 8'h00);
        send_item(ACT_APPEND, 8'hFF);
        send_item(ACT_APPEND, 8'h5A);
        send_item(ACT_APPEND, 8'hFF);     // duplicate card
        send_item(ACT_UNUSED, 8'hA5);     // ignored action code
        send_item(ACT_QUERY, 8'hA5);      // absent card
        send_item(ACT_QUERY, 8'h00);      // front entry, no move
        send_item(ACT_QUERY, 8'hFF);      // first of two equal entries
        send_item(ACT_QUERY, 8'h5A);
        send_item(ACT_QUERY, 8'hFF);
        send_item(ACT_APPEND, 8'h81);
        send_item(ACT_QUERY, 8'h81);      // last entry of the list
        send_item(ACT_RESTART, 8'hFF);
        send_item(ACT_QUERY, 8'hFF);      // list emptied by the restart
        send_item(ACT_RESTART, 8'h00);    // restart of an empty list
        send_item(ACT_APPEND, 8'h3C);
        send_item(ACT_QUERY, 8'h3C);

        // random phases: sender idles rarely, then receiver rarely, then none
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 7;
                    recv_idle_pct = 50;
                end
                1:
                begin
                    send_idle_pct = 50;
                    recv_idle_pct = 7;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            play_full_list();
            while (items_taken < (phase + 1) * PHASE_ITEMS)
                play_small_list();
        end

        @(negedge clk);
        in_ch.valid <= 1'b0;

        // wait for the outstanding results, then watch for stray ones
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (4 * QUERY_CYCLES) @(posedge clk);

        if (tracker.failures() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial
    begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
